>>> design/ncr_pkg.sv
// ncr_pkg: shared types, constants and the cp1252 remap table for the
// numeric character reference decoder. No dependencies.
package ncr_pkg;

   localparam int unsigned CharWidth  = 16;
   localparam int unsigned CpWidth    = 21;
   localparam int unsigned CountWidth = 8;
   // wide enough for accum * 16 + 15
   localparam int unsigned SumWidth   = CpWidth + 5;

   localparam logic [CpWidth-1:0]    CpMax     = 21'h10FFFF;
   localparam logic [CpWidth-1:0]    CpReplace = 21'h00FFFD;
   localparam logic [CpWidth-1:0]    SurrLow   = 21'h00D800;
   localparam logic [CpWidth-1:0]    SurrHigh  = 21'h00DFFF;
   localparam logic [CountWidth-1:0] CountMax  = 8'hFF;

   localparam logic [CharWidth-1:0] ChTab   = 16'h0009;
   localparam logic [CharWidth-1:0] ChLf    = 16'h000A;
   localparam logic [CharWidth-1:0] ChFf    = 16'h000C;
   localparam logic [CharWidth-1:0] ChSpace = 16'h0020;
   localparam logic [CharWidth-1:0] ChLt    = 16'h003C;
   localparam logic [CharWidth-1:0] ChAmp   = 16'h0026;
   localparam logic [CharWidth-1:0] ChHash  = 16'h0023;
   localparam logic [CharWidth-1:0] ChSemi  = 16'h003B;
   localparam logic [CharWidth-1:0] ChLowX  = 16'h0078;
   localparam logic [CharWidth-1:0] ChUpX   = 16'h0058;

   typedef enum logic [2:0] {
      ST_PENDING  = 3'd0,
      ST_DECODED  = 3'd1,
      ST_NOREF    = 3'd2,
      ST_NAMED    = 3'd3,
      ST_NEEDMORE = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      MODE_INITIAL  = 5'b00001,
      MODE_NUMTYPE  = 5'b00010,
      MODE_MAYBEHEX = 5'b00100,
      MODE_HEX      = 5'b01000,
      MODE_DEC      = 5'b10000
   } parse_mode_type;

   typedef struct packed {
      parse_mode_type          mode;
      logic [CpWidth-1:0]      accum;
      logic                    overflow;
      logic [CountWidth-1:0]   taken;
   } parse_state_type;

   typedef struct packed {
      status_type              status;
      logic [CpWidth-1:0]      code_point;
      logic                    char_consumed;
      logic [CountWidth-1:0]   replay_count;
   } result_type;

   localparam parse_state_type ParseReset = '{
      mode:     MODE_INITIAL,
      accum:    '0,
      overflow: 1'b0,
      taken:    '0
   };

   // windows-1252 remap of 0x80..0x9f
   function automatic logic [CharWidth-1:0] cp1252_high(input logic [4:0] idx);
      logic [CharWidth-1:0] val;
      unique case (idx)
         5'd0:  val = 16'h20AC;
         5'd1:  val = 16'h0081;
         5'd2:  val = 16'h201A;
         5'd3:  val = 16'h0192;
         5'd4:  val = 16'h201E;
         5'd5:  val = 16'h2026;
         5'd6:  val = 16'h2020;
         5'd7:  val = 16'h2021;
         5'd8:  val = 16'h02C6;
         5'd9:  val = 16'h2030;
         5'd10: val = 16'h0160;
         5'd11: val = 16'h2039;
         5'd12: val = 16'h0152;
         5'd13: val = 16'h008D;
         5'd14: val = 16'h017D;
         5'd15: val = 16'h008F;
         5'd16: val = 16'h0090;
         5'd17: val = 16'h2018;
         5'd18: val = 16'h2019;
         5'd19: val = 16'h201C;
         5'd20: val = 16'h201D;
         5'd21: val = 16'h2022;
         5'd22: val = 16'h2013;
         5'd23: val = 16'h2014;
         5'd24: val = 16'h02DC;
         5'd25: val = 16'h2122;
         5'd26: val = 16'h0161;
         5'd27: val = 16'h203A;
         5'd28: val = 16'h0153;
         5'd29: val = 16'h009D;
         5'd30: val = 16'h017E;
         5'd31: val = 16'h0178;
         default: val = 16'h0178;
      endcase
      return val;
   endfunction

endpackage

>>> design/ncr_req_if.sv
// ncr_req_if: input character channel (valid/ready plus op and char_in).
// Depends on ncr_pkg.
interface ncr_req_if;
   import ncr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [CharWidth-1:0] char_in;

   modport source (output valid, output op, output char_in, input ready);
   modport sink   (input valid, input op, input char_in, output ready);
endinterface

>>> design/ncr_rsp_if.sv
// ncr_rsp_if: result channel (valid/ready plus status, code point, consumed, replay).
// Depends on ncr_pkg.
interface ncr_rsp_if;
   import ncr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [2:0]            status;
   logic [CpWidth-1:0]    code_point;
   logic                  char_consumed;
   logic [CountWidth-1:0] replay_count;

   modport source (output valid, output status, output code_point,
                   output char_consumed, output replay_count, input ready);
   modport sink   (input valid, input status, input code_point,
                   input char_consumed, input replay_count, output ready);
endinterface

>>> design/ncr_csr_if.sv
// ncr_csr_if: configuration write channel for the extra stop character.
// Depends on ncr_pkg.
interface ncr_csr_if;
   import ncr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> design/ncr_legalize.sv
// ncr_legalize: maps an accumulated code point to a legal one
// (replacement char, cp1252 remap). Depends on ncr_pkg.
module ncr_legalize (
   input  logic [ncr_pkg::CpWidth-1:0] accum,
   input  logic                        overflow,
   output logic [ncr_pkg::CpWidth-1:0] code_point
);
   import ncr_pkg::*;

   logic bad_value;
   logic c1_range;

   assign bad_value = overflow || (accum == '0) || (accum > CpMax) ||
                      ((accum >= SurrLow) && (accum <= SurrHigh));
   // 0x80..0x9f
   assign c1_range  = (accum[CpWidth-1:5] == 16'h0004);

   always_comb begin
      priority if (bad_value) begin
         code_point = CpReplace;
      end else if (c1_range) begin
         code_point = {{(CpWidth-CharWidth){1'b0}}, cp1252_high(accum[4:0])};
      end else begin
         code_point = accum;
      end
   end

endmodule

>>> design/ncr_step.sv
// ncr_step: next-state and result logic for one character transaction.
// Depends on ncr_pkg and ncr_legalize.
module ncr_step (
   input  logic                          op,
   input  logic [ncr_pkg::CharWidth-1:0] char_in,
   input  logic [ncr_pkg::CharWidth-1:0] extra_stop_char,
   input  ncr_pkg::parse_state_type      state,
   output ncr_pkg::parse_state_type      state_next,
   output ncr_pkg::result_type           result
);
   import ncr_pkg::*;

   logic                  is_dec;
   logic                  is_hex_alpha;
   logic                  is_letter;
   logic                  is_stop;
   logic [3:0]            digit_val;
   logic                  use_hex;
   logic                  first_digit;
   logic [CpWidth-1:0]    acc_base;
   logic [SumWidth-1:0]   acc_wide;
   logic [SumWidth-1:0]   acc_sum;
   logic                  acc_ovf;
   logic [CpWidth-1:0]    acc_sat;
   logic [CountWidth-1:0] taken_inc;
   logic [CpWidth-1:0]    legal_cp;

   assign is_dec       = (char_in >= 16'h0030) && (char_in <= 16'h0039);
   assign is_hex_alpha = ((char_in >= 16'h0061) && (char_in <= 16'h0066)) ||
                         ((char_in >= 16'h0041) && (char_in <= 16'h0046));
   assign is_letter    = ((char_in >= 16'h0061) && (char_in <= 16'h007A)) ||
                         ((char_in >= 16'h0041) && (char_in <= 16'h005A));
   assign is_stop      = (char_in == ChTab) || (char_in == ChLf) || (char_in == ChFf) ||
                         (char_in == ChSpace) || (char_in == ChLt) || (char_in == ChAmp) ||
                         ((extra_stop_char != '0) && (char_in == extra_stop_char));
   // 'a'/'A' low nibble is 1, so +9 gives 10
   assign digit_val    = is_dec ? char_in[3:0] : 4'(char_in[3:0] + 4'd9);

   assign use_hex     = (state.mode == MODE_MAYBEHEX) || (state.mode == MODE_HEX);
   assign first_digit = (state.mode == MODE_NUMTYPE) || (state.mode == MODE_MAYBEHEX);
   assign acc_base    = first_digit ? '0 : state.accum;
   assign acc_wide    = {{(SumWidth-CpWidth){1'b0}}, acc_base};

   // shift-add: x16 or x8 + x2
   assign acc_sum = use_hex
                    ? ((acc_wide << 4) + {{(SumWidth-4){1'b0}}, digit_val})
                    : ((acc_wide << 3) + (acc_wide << 1) + {{(SumWidth-4){1'b0}}, digit_val});
   assign acc_ovf = (acc_sum > {{(SumWidth-CpWidth){1'b0}}, CpMax});
   assign acc_sat = acc_ovf ? CpMax : acc_sum[CpWidth-1:0];

   assign taken_inc = (state.taken == CountMax) ? state.taken
                                                : CountWidth'(state.taken + 1'b1);

   ncr_legalize u_legalize (
      .accum      (state.accum),
      .overflow   (state.overflow),
      .code_point (legal_cp)
   );

   always_comb begin
      state_next = state;
      result     = '{status: ST_PENDING, code_point: '0, char_consumed: 1'b0,
                     replay_count: '0};
      if (op) begin
         result.status       = ST_NEEDMORE;
         result.replay_count = state.taken;
         state_next          = ParseReset;
      end else begin
         unique case (state.mode)
            MODE_NUMTYPE, MODE_MAYBEHEX: begin
               if ((state.mode == MODE_NUMTYPE) &&
                   ((char_in == ChLowX) || (char_in == ChUpX))) begin
                  result.char_consumed = 1'b1;
                  state_next.taken     = taken_inc;
                  state_next.mode      = MODE_MAYBEHEX;
               end else if (is_dec || (use_hex && is_hex_alpha)) begin
                  result.char_consumed = 1'b1;
                  state_next.taken     = taken_inc;
                  state_next.accum     = acc_sat;
                  state_next.overflow  = acc_ovf;
                  state_next.mode      = use_hex ? MODE_HEX : MODE_DEC;
               end else begin
                  result.status       = ST_NOREF;
                  result.replay_count = state.taken;
                  state_next          = ParseReset;
               end
            end
            MODE_HEX, MODE_DEC: begin
               if (is_dec || (use_hex && is_hex_alpha)) begin
                  result.char_consumed = 1'b1;
                  state_next.taken     = taken_inc;
                  state_next.accum     = acc_sat;
                  state_next.overflow  = state.overflow | acc_ovf;
               end else begin
                  result.status        = ST_DECODED;
                  result.char_consumed = (char_in == ChSemi);
                  result.code_point    = legal_cp;
                  state_next           = ParseReset;
               end
            end
            default: begin
               // initial mode, also any stray code
               priority if (is_stop) begin
                  result.status = ST_NOREF;
                  state_next    = ParseReset;
               end else if (char_in == ChHash) begin
                  result.char_consumed = 1'b1;
                  state_next           = ParseReset;
                  state_next.taken     = taken_inc;
                  state_next.mode      = MODE_NUMTYPE;
               end else if (is_letter) begin
                  result.status = ST_NAMED;
                  state_next    = ParseReset;
               end else begin
                  result.status = ST_NOREF;
                  state_next    = ParseReset;
               end
            end
         endcase
      end
   end

endmodule

>>> design/numeric_char_reference_decoder_core.sv
// numeric_char_reference_decoder_core: top level of the numeric character
// reference decoder. Depends on ncr_pkg, the ncr_*_if interfaces and ncr_step.
// The result of an accepted character is registered in the output register.
// Accepts one character per cycle while req_bus.ready is high; the parse state register feeds back through ncr_step.
// req_bus.ready drops only while a result is held and rsp_bus.ready is low.
// Synchronous active-high reset clears parse state, the stop character and rsp valid.
module numeric_char_reference_decoder_core (
   input  logic  clock,
   input  logic  reset,
   ncr_req_if.sink   req_bus,
   ncr_rsp_if.source rsp_bus,
   ncr_csr_if.sink   csr_bus
);
   import ncr_pkg::*;

   parse_state_type      state_ff, state_in;
   parse_state_type      step_state;
   result_type           step_result;
   result_type           result_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0] stop_char_ff, stop_char_in;
   logic                 req_take;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   ncr_step u_step (
      .op              (req_bus.op),
      .char_in         (req_bus.char_in),
      .extra_stop_char (stop_char_ff),
      .state           (state_ff),
      .state_next      (step_state),
      .result          (step_result)
   );

   assign state_in     = req_take ? step_state : state_ff;
   assign rsp_valid_in = req_take ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);
   assign stop_char_in = (csr_bus.valid && csr_bus.ready) ? csr_bus.data : stop_char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ParseReset;
         rsp_valid_ff <= 1'b0;
         stop_char_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         stop_char_ff <= stop_char_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= step_result;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = result_ff.status;
   assign rsp_bus.code_point    = result_ff.code_point;
   assign rsp_bus.char_consumed = result_ff.char_consumed;
   assign rsp_bus.replay_count  = result_ff.replay_count;

endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for numeric_char_reference_decoder_core.
// Depends on ncr_pkg, ncr_req_if, ncr_rsp_if, ncr_csr_if and the core; a class
// predicts each result from the characters sent and checks it on the rsp channel.
module tb_top;
   import ncr_pkg::*;

   localparam int unsigned HalfPeriod  = 4;
   localparam int unsigned ResetCycles = 12;
   localparam int unsigned PhaseQuota  = 120;
   localparam int unsigned LongRunLen  = 256;
   localparam int unsigned DrainCycles = 4;
   localparam longint unsigned CycleLimit = 500000;

   class charref_board;
      parse_mode_type        mode;
      logic [CpWidth-1:0]    accum;
      logic                  overflow;
      logic [CountWidth-1:0] taken;
      logic [CharWidth-1:0]  stop_char;
      logic [CharWidth-1:0]  win1252 [32];
      result_type            expected_q [$];
      int unsigned           errors;

      function new();
         win1252 = '{16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020,
                     16'h2021, 16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D,
                     16'h017D, 16'h008F, 16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D,
                     16'h2022, 16'h2013, 16'h2014, 16'h02DC, 16'h2122, 16'h0161, 16'h203A,
                     16'h0153, 16'h009D, 16'h017E, 16'h0178};
         stop_char = '0;
         errors    = 0;
         restart();
      endfunction

      function void restart();
         mode     = MODE_INITIAL;
         accum    = '0;
         overflow = 1'b0;
         taken    = '0;
      endfunction

      function void count_taken();
         if (taken != CountMax) taken = taken + 1'b1;
      endfunction

      function int digit_value(logic [CharWidth-1:0] c, bit hex);
         if (c >= "0" && c <= "9") return int'(c - "0");
         if (hex && c >= "a" && c <= "f") return int'(c - "a") + 10;
         if (hex && c >= "A" && c <= "F") return int'(c - "A") + 10;
         return -1;
      endfunction

      // saturate at the top code point, sticky overflow forces replacement
      function void add_digit(int d, bit hex);
         int unsigned wide;
         wide = accum * (hex ? 16 : 10) + d;
         if (wide > CpMax) begin
            overflow = 1'b1;
            accum    = CpMax;
         end else begin
            accum = wide[CpWidth-1:0];
         end
      endfunction

      function logic [CpWidth-1:0] legal_cp();
         if (overflow || accum == 0 || accum > CpMax || (accum >= SurrLow && accum <= SurrHigh))
            return CpReplace;
         if ((accum & ~21'h1F) == 21'h80) return {5'b0, win1252[accum[4:0]]};
         return accum;
      endfunction

      function void predict_char(bit op_bit, logic [CharWidth-1:0] c);
         result_type r;
         int         d;
         bit         hex;
         r.status        = ST_PENDING;
         r.code_point    = '0;
         r.char_consumed = 1'b0;
         r.replay_count  = '0;
         if (op_bit) begin
            r.status       = ST_NEEDMORE;
            r.replay_count = taken;
            restart();
         end else begin
            case (mode)
               MODE_INITIAL: begin
                  if (c == ChTab || c == ChLf || c == ChFf || c == ChSpace || c == ChLt ||
                      c == ChAmp || (stop_char != 0 && c == stop_char)) begin
                     r.status = ST_NOREF;
                  end else if (c == ChHash) begin
                     r.char_consumed = 1'b1;
                     count_taken();
                     mode = MODE_NUMTYPE;
                  end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
                     r.status = ST_NAMED;
                  end else begin
                     r.status = ST_NOREF;
                  end
                  if (r.status != ST_PENDING) restart();
               end
               MODE_NUMTYPE, MODE_MAYBEHEX: begin
                  hex = (mode == MODE_MAYBEHEX);
                  d   = digit_value(c, hex);
                  if (!hex && (c == ChLowX || c == ChUpX)) begin
                     r.char_consumed = 1'b1;
                     count_taken();
                     mode = MODE_MAYBEHEX;
                  end else if (d >= 0) begin
                     // first digit is taken in the same step
                     r.char_consumed = 1'b1;
                     count_taken();
                     accum    = '0;
                     overflow = 1'b0;
                     add_digit(d, hex);
                     if (hex) mode = MODE_HEX;
                     else mode = MODE_DEC;
                  end else begin
                     r.status       = ST_NOREF;
                     r.replay_count = taken;
                     restart();
                  end
               end
               default: begin
                  hex = (mode == MODE_HEX);
                  d   = digit_value(c, hex);
                  if (d >= 0) begin
                     r.char_consumed = 1'b1;
                     count_taken();
                     add_digit(d, hex);
                  end else begin
                     r.status        = ST_DECODED;
                     r.char_consumed = (c == ChSemi);
                     r.code_point    = legal_cp();
                     restart();
                  end
               end
            endcase
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [2:0] status, logic [CpWidth-1:0] cp, logic consumed,
                                 logic [CountWidth-1:0] replay);
         result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result: status %0d code point %h consumed %b replay %0d",
                     $time, status, cp, consumed, replay);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, status);
            errors++;
         end
         if (cp !== want.code_point) begin
            $display("%0t: code point mismatch: expected %h actual %h",
                     $time, want.code_point, cp);
            errors++;
         end
         if (consumed !== want.char_consumed) begin
            $display("%0t: char consumed mismatch: expected %b actual %b",
                     $time, want.char_consumed, consumed);
            errors++;
         end
         if (replay !== want.replay_count) begin
            $display("%0t: replay count mismatch: expected %0d actual %0d",
                     $time, want.replay_count, replay);
            errors++;
         end
      endfunction

      function int unsigned waiting();
         return expected_q.size();
      endfunction

      function void report_leftover();
         foreach (expected_q[i]) begin
            $display("%0t: result never arrived: status %0d code point %h",
                     $time, expected_q[i].status, expected_q[i].code_point);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ncr_req_if req_bus ();
   ncr_rsp_if rsp_bus ();
   ncr_csr_if csr_bus ();

   numeric_char_reference_decoder_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   charref_board          decode_board;
   int unsigned           items_sent  = 0;
   bit                    src_steady  = 1'b0;
   bit                    sink_steady = 1'b0;
   int unsigned           sink_hold   = 0;
   longint unsigned       cycles_run  = 0;
   logic [CharWidth-1:0]  stop_set [6]   = '{ChTab, ChLf, ChFf, ChSpace, ChLt, ChAmp};
   logic [CharWidth-1:0]  border_set [6] = '{16'h002F, 16'h003A, 16'h0040, 16'h005B,
                                             16'h0060, 16'h007B};
   int unsigned           border_cps [6] = '{32'hD7FF, 32'hE000, 32'h7F, 32'hA0,
                                             32'hFFFE, 32'hFFFF};
   logic [CharWidth-1:0]  phase_stops [6] = '{16'hFFFF, 16'h0001, 16'h0061, ChHash,
                                              16'h0000, 16'h0000};

   initial clock = 1'b0;
   always #HalfPeriod clock = ~clock;

   function automatic int unsigned idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [CharWidth-1:0] any_char();
      return CharWidth'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic int unsigned pick_code_value();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom_range(32'h80, 32'h9F);
         2: return $urandom_range(32'hD800, 32'hDFFF);
         3: return $urandom_range(32'h10FFFE, 32'h110001);
         4: return $urandom();
         5: return $urandom_range(1, 32'h7F);
         6: return $urandom_range(32'hA0, 32'hFFFF);
         7: return $urandom_range(32'h10000, 32'h10FFFF);
         8: return border_cps[$urandom_range(0, 5)];
         default: return $urandom_range(32'h110000, 32'h7FFFFFF);
      endcase
   endfunction

   // result side: random stalls, with quiet stretches now and then
   always @(negedge clock) begin
      if (sink_hold != 0) begin
         sink_hold      <= sink_hold - 1;
         rsp_bus.ready  <= 1'b0;
      end else begin
         rsp_bus.ready  <= 1'b1;
         if (!sink_steady) sink_hold <= idle_len();
      end
      if ($urandom_range(0, 63) == 0) sink_steady <= ~sink_steady;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         decode_board.check_result(rsp_bus.status, rsp_bus.code_point,
                                   rsp_bus.char_consumed, rsp_bus.replay_count);
   end

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CycleLimit) begin
         $display("%0t: timed out after %0d cycles", $time, cycles_run);
         $display("Some tests failed");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic send_item(input bit op_bit, input logic [CharWidth-1:0] ch);
      int unsigned gap;
      gap = src_steady ? 0 : idle_len();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.op      <= op_bit;
      req_bus.char_in <= ch;
      do @(posedge clock); while (!req_bus.ready);
      decode_board.predict_char(op_bit, ch);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_end();
      send_item(1'b1, any_char());
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_item(1'b0, {8'h00, s[i]});
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (decode_board.waiting() != 0) @(negedge clock);
   endtask

   task automatic write_stop_char(input logic [CharWidth-1:0] value);
      drain_results();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      decode_board.stop_char = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_number(input bit hex, input int unsigned value);
      string       digits;
      byte         ch;
      int unsigned zeros;
      int unsigned ending;
      zeros  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
      digits = hex ? $sformatf("%0h", value) : $sformatf("%0d", value);
      send_item(1'b0, ChHash);
      if (hex) send_item(1'b0, $urandom_range(0, 1) ? ChUpX : ChLowX);
      repeat (zeros) send_item(1'b0, {8'h00, "0"});
      foreach (digits[i]) begin
         ch = digits[i];
         if (ch >= "a" && $urandom_range(0, 1) != 0) ch = ch - 8'd32;
         send_item(1'b0, {8'h00, ch});
      end
      ending = $urandom_range(0, 9);
      if (ending < 6) send_item(1'b0, ChSemi);
      else if (ending < 9) send_item(1'b0, $urandom_range(0, 1) ? border_set[ending - 6]
                                                               : any_char());
      else send_end();
   endtask

   task automatic send_broken();
      case ($urandom_range(0, 5))
         0: begin
            send_item(1'b0, ChHash);
            send_item(1'b0, any_char());
         end
         1: begin
            send_item(1'b0, ChHash);
            send_item(1'b0, ChLowX);
            send_item(1'b0, $urandom_range(0, 1) ? border_set[$urandom_range(0, 5)]
                                                 : any_char());
         end
         2: begin
            send_item(1'b0, ChHash);
            send_end();
         end
         3: begin
            send_item(1'b0, ChHash);
            send_item(1'b0, ChUpX);
            send_end();
         end
         4: send_end();
         default: begin
            send_item(1'b0, ChHash);
            send_item(1'b0, ChHash);
         end
      endcase
   endtask

   task automatic send_start_char();
      logic [CharWidth-1:0] c;
      case ($urandom_range(0, 4))
         0: c = stop_set[$urandom_range(0, 5)];
         1: c = decode_board.stop_char;
         2: begin
            c = 16'h0041 + CharWidth'($urandom_range(0, 25));
            if ($urandom_range(0, 1) != 0) c = c + 16'h0020;
         end
         3: c = border_set[$urandom_range(0, 5)];
         default: c = any_char();
      endcase
      send_item(1'b0, c);
   endtask

   task automatic run_phase(input int unsigned quota);
      int unsigned start;
      int unsigned roll;
      start = items_sent;
      while (items_sent - start < quota) begin
         if ($urandom_range(0, 19) == 0) src_steady = ~src_steady;
         roll = $urandom_range(0, 99);
         if (roll < 70) send_number($urandom_range(0, 1), pick_code_value());
         else if (roll < 80) send_broken();
         else if (roll < 90) send_start_char();
         else begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 7) == 0) send_end();
               else send_item(1'b0, any_char());
            end
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.op      = 1'b0;
      req_bus.char_in = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.data    = '0;
      rsp_bus.ready   = 1'b0;
      decode_board    = new();
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_stop_char('0);
      send_text("#X80;");
      send_text("#0;");
      send_text("#9z");
      send_text("a");
      send_item(1'b0, ChTab);
      send_item(1'b0, ChLt);
      send_text("!");
      send_text("#q");
      send_text("#x;");
      send_item(1'b0, ChHash);
      send_end();
      send_item(1'b0, 16'hFFFF);
      send_item(1'b0, 16'h0000);
      send_end();
      run_phase(PhaseQuota);

      phase_stops[4] = any_char();
      foreach (phase_stops[i]) begin
         write_stop_char(phase_stops[i]);
         if (i == 1) begin
            // long zero run so the taken count saturates before end of data
            send_item(1'b0, ChHash);
            send_item(1'b0, ChLowX);
            repeat (LongRunLen) send_item(1'b0, {8'h00, "0"});
            send_end();
         end
         run_phase(PhaseQuota);
      end

      drain_results();
      repeat (DrainCycles) @(negedge clock);
      decode_board.report_leftover();
      if (decode_board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
